// ===== src/adts_pkg.sv =====
package adts_pkg;

   localparam logic [1:0] PH_HUNT  = 2'd0;
   localparam logic [1:0] PH_HELD  = 2'd1;
   localparam logic [1:0] PH_FRAME = 2'd2;

   localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE = 4'hF;
   localparam logic [12:0] HDR_BYTES   = 13'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_class;
      logic        first_of_frame;
      logic        end_of_frame;
      logic        header_done;
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [12:0] frame_length;
      logic [15:0] bytes_skipped;
      logic [15:0] frame_count;
      logic        length_error;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// ===== src/adts_frame_deframer.sv =====
// ADTS frame deframer. Raw stream bytes enter on the req_ channel, one beat
// per byte, and released bytes leave on the rsp_ channel, one beat per byte.
// A byte can release zero, one or two beats: a 0xFF seen while hunting is
// held until the next byte, which then releases both. The last beat caused
// by a request beat carries rsp_last_result.
// Each request beat is decoded in the cycle it is accepted and its beats are
// registered into a four-entry result queue, whose head drives the rsp_
// port. Throughput is one request beat per cycle while the receiver keeps
// up; a byte that releases two beats drains as two separate rsp_ beats.
// req_ready is high while the queue has room for two more beats, so a
// stalled receiver backs the input up once three or four beats are queued,
// and no beat is ever dropped.
// Synchronous reset returns the parser to hunting for sync, clears the
// skip and frame counters and the latched header fields, and empties the
// queue; a held 0xFF is discarded.
module adts_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_class,
   output logic        rsp_first_of_frame,
   output logic        rsp_end_of_frame,
   output logic        rsp_header_done,
   output logic [1:0]  rsp_profile,
   output logic [3:0]  rsp_rate_index,
   output logic [12:0] rsp_frame_length,
   output logic [15:0] rsp_bytes_skipped,
   output logic [15:0] rsp_frame_count,
   output logic        rsp_length_error,
   output logic        rsp_last_result
);
   import adts_pkg::*;

   push_type   push;
   result_type head;
   logic       room;
   logic       accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   adts_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .push      (push)
   );

   adts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && rsp_ready),
      .room      (room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_out_byte       = head.out_byte;
   assign rsp_byte_class     = head.byte_class;
   assign rsp_first_of_frame = head.first_of_frame;
   assign rsp_end_of_frame   = head.end_of_frame;
   assign rsp_header_done    = head.header_done;
   assign rsp_profile        = head.profile;
   assign rsp_rate_index     = head.rate_index;
   assign rsp_frame_length   = head.frame_length;
   assign rsp_bytes_skipped  = head.bytes_skipped;
   assign rsp_frame_count    = head.frame_count;
   assign rsp_length_error   = head.length_error;
   assign rsp_last_result    = head.last_result;

endmodule

// ===== src/adts_core.sv =====
module adts_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   output adts_pkg::push_type push
);
   import adts_pkg::*;

   localparam logic [12:0] POS_PROF  = 13'd2;
   localparam logic [12:0] POS_LEN_A = 13'd3;
   localparam logic [12:0] POS_LEN_B = 13'd4;
   localparam logic [12:0] POS_LEN_C = 13'd5;
   localparam logic [12:0] POS_HDR   = 13'd6;

   logic [1:0]  phase_ff, phase_in;
   logic [12:0] pos_ff, pos_in;
   logic [1:0]  prof_ff, prof_in;
   logic [3:0]  rate_ff, rate_in;
   logic [12:0] len_ff, len_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] frame_ff, frame_in;

   logic [15:0] skip_one;
   logic [15:0] skip_two;
   logic [13:0] pos_next;
   logic        hdr;
   logic        show;
   logic        frame_end;
   logic        lerr;

   function automatic result_type mk(
      input logic [7:0]  b,
      input logic        cls,
      input logic        first,
      input logic        eof,
      input logic        hdr_f,
      input logic        show_f,
      input logic        lerr_f,
      input logic [15:0] skip,
      input logic [15:0] fcnt,
      input logic [1:0]  prof,
      input logic [3:0]  rate,
      input logic [12:0] len,
      input logic        last
   );
      result_type r;
      r.out_byte       = b;
      r.byte_class     = cls;
      r.first_of_frame = first;
      r.end_of_frame   = eof;
      r.header_done    = hdr_f;
      r.profile        = show_f ? prof : 2'd0;
      r.rate_index     = show_f ? rate : 4'd0;
      r.frame_length   = show_f ? len : 13'd0;
      r.bytes_skipped  = skip;
      r.frame_count    = fcnt;
      r.length_error   = lerr_f;
      r.last_result    = last;
      return r;
   endfunction

   assign skip_one = (skip_ff == 16'hFFFF) ? skip_ff : skip_ff + 16'd1;
   assign skip_two = (skip_one == 16'hFFFF) ? skip_one : skip_one + 16'd1;
   assign pos_next = {1'b0, pos_ff} + 14'd1;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      prof_in  = prof_ff;
      rate_in  = rate_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      frame_in = frame_ff;
      hdr       = 1'b0;
      show      = 1'b0;
      frame_end = 1'b0;
      lerr      = 1'b0;
      push      = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (data_byte == SYNC_BYTE) begin
                  phase_in = PH_HELD;
               end else begin
                  skip_in  = skip_one;
                  push.cnt = 2'd1;
                  push.r0  = mk(data_byte, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                skip_one, frame_ff, prof_ff, rate_ff, len_ff, 1'b1);
               end
            end
            PH_HELD: begin
               if (data_byte[7:4] == SYNC_NIBBLE) begin
                  prof_in  = 2'd0;
                  rate_in  = 4'd0;
                  len_in   = 13'd0;
                  push.cnt = 2'd2;
                  push.r0  = mk(SYNC_BYTE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                skip_ff, frame_ff, prof_ff, rate_ff, len_ff, 1'b0);
                  push.r1  = mk(data_byte, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                skip_ff, frame_ff, prof_ff, rate_ff, len_ff, 1'b1);
                  pos_in   = POS_PROF;
                  phase_in = PH_FRAME;
               end else if (data_byte == SYNC_BYTE) begin
                  skip_in  = skip_one;
                  push.cnt = 2'd1;
                  push.r0  = mk(SYNC_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                skip_one, frame_ff, prof_ff, rate_ff, len_ff, 1'b1);
               end else begin
                  skip_in  = skip_two;
                  push.cnt = 2'd2;
                  push.r0  = mk(SYNC_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                skip_one, frame_ff, prof_ff, rate_ff, len_ff, 1'b0);
                  push.r1  = mk(data_byte, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                skip_two, frame_ff, prof_ff, rate_ff, len_ff, 1'b1);
                  phase_in = PH_HUNT;
               end
            end
            PH_FRAME: begin
               if (pos_ff == POS_PROF) begin
                  prof_in = data_byte[7:6];
                  rate_in = data_byte[5:2];
               end else if (pos_ff == POS_LEN_A) begin
                  len_in = {data_byte[1:0], 11'd0};
               end else if (pos_ff == POS_LEN_B) begin
                  len_in = len_ff | {2'd0, data_byte, 3'd0};
               end else if (pos_ff == POS_LEN_C) begin
                  len_in = len_ff | {10'd0, data_byte[7:5]};
               end
               if (pos_ff == POS_HDR) begin
                  hdr       = 1'b1;
                  show      = 1'b1;
                  lerr      = (len_in < HDR_BYTES);
                  frame_end = (len_in <= HDR_BYTES);
               end else begin
                  show      = (pos_ff > POS_HDR);
                  frame_end = show && (pos_next >= {1'b0, len_in});
               end
               push.cnt = 2'd1;
               push.r0  = mk(data_byte, 1'b1, 1'b0, frame_end, hdr, show, lerr,
                             skip_ff, frame_ff, prof_in, rate_in, len_in, 1'b1);
               if (frame_end) begin
                  frame_in = frame_ff + 16'd1;
                  skip_in  = 16'd0;
                  pos_in   = 13'd0;
                  phase_in = PH_HUNT;
               end else begin
                  pos_in = pos_next[12:0];
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= 13'd0;
         prof_ff  <= 2'd0;
         rate_ff  <= 4'd0;
         len_ff   <= 13'd0;
         skip_ff  <= 16'd0;
         frame_ff <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         prof_ff  <= prof_in;
         rate_ff  <= rate_in;
         len_ff   <= len_in;
         skip_ff  <= skip_in;
         frame_ff <= frame_in;
      end
   end

endmodule

// ===== src/adts_queue.sv =====
module adts_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  adts_pkg::push_type   push,
   input  logic                 pop,
   output logic                 room,
   output logic                 not_empty,
   output adts_pkg::result_type head
);
   import adts_pkg::*;

   result_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in;
   logic [QPTR_W-1:0]       rd_ff, rd_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic [QPTR_W-1:0]       wr_next;

   assign wr_next   = wr_ff + QPTR_W'(1);
   assign room      = (count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff + QPTR_W'(push.cnt);
      rd_in    = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push.cnt) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         entry_ff[wr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         entry_ff[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sim/tb_adts_frame_deframer.sv =====
module tb_adts_frame_deframer;
   import adts_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_class;
   logic        rsp_first_of_frame;
   logic        rsp_end_of_frame;
   logic        rsp_header_done;
   logic [1:0]  rsp_profile;
   logic [3:0]  rsp_rate_index;
   logic [12:0] rsp_frame_length;
   logic [15:0] rsp_bytes_skipped;
   logic [15:0] rsp_frame_count;
   logic        rsp_length_error;
   logic        rsp_last_result;

   adts_frame_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_class(rsp_byte_class),
      .rsp_first_of_frame(rsp_first_of_frame),
      .rsp_end_of_frame(rsp_end_of_frame),
      .rsp_header_done(rsp_header_done),
      .rsp_profile(rsp_profile),
      .rsp_rate_index(rsp_rate_index),
      .rsp_frame_length(rsp_frame_length),
      .rsp_bytes_skipped(rsp_bytes_skipped),
      .rsp_frame_count(rsp_frame_count),
      .rsp_length_error(rsp_length_error),
      .rsp_last_result(rsp_last_result)
   );

   always #4 clock = ~clock;

   // Parser state mirrored by the predictor.
   logic [1:0]  parse_phase = PH_HUNT;
   logic [12:0] frame_pos = 13'd0;
   logic [1:0]  hdr_profile = 2'd0;
   logic [3:0]  hdr_rate = 4'd0;
   logic [12:0] hdr_length = 13'd0;
   logic [15:0] skip_count = 16'd0;
   logic [15:0] frame_index = 16'd0;

   result_type pending_beats[$];
   bit         idle_on = 1'b1;
   int         bytes_sent = 0;
   int         mismatches = 0;
   int         stall_cycles = 0;

   function automatic result_type make_beat(input logic [7:0] b, input logic cls,
                                            input logic first, input logic eof,
                                            input logic hdr, input logic show,
                                            input logic lerr);
      result_type r;
      r.out_byte       = b;
      r.byte_class     = cls;
      r.first_of_frame = first;
      r.end_of_frame   = eof;
      r.header_done    = hdr;
      r.profile        = show ? hdr_profile : 2'd0;
      r.rate_index     = show ? hdr_rate : 4'd0;
      r.frame_length   = show ? hdr_length : 13'd0;
      r.bytes_skipped  = skip_count;
      r.frame_count    = frame_index;
      r.length_error   = lerr;
      r.last_result    = 1'b0;
      return r;
   endfunction

   task automatic count_skip();
      if (skip_count != 16'hFFFF) skip_count = skip_count + 16'd1;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      result_type beats[2];
      int         n;
      int         nxt;
      logic       show;
      logic       done;
      n = 0;
      done = 1'b0;
      case (parse_phase)
         PH_HUNT: begin
            if (b == SYNC_BYTE) begin
               parse_phase = PH_HELD;
            end else begin
               count_skip();
               beats[0] = make_beat(b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
               n = 1;
            end
         end
         PH_HELD: begin
            if (b[7:4] == SYNC_NIBBLE) begin
               hdr_profile = 2'd0;
               hdr_rate = 4'd0;
               hdr_length = 13'd0;
               beats[0] = make_beat(SYNC_BYTE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
               beats[1] = make_beat(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
               n = 2;
               frame_pos = 13'd2;
               parse_phase = PH_FRAME;
            end else begin
               count_skip();
               beats[0] = make_beat(SYNC_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
               count_skip();
               beats[1] = make_beat(b, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
               n = 2;
               parse_phase = PH_HUNT;
            end
         end
         default: begin
            if (frame_pos == 13'd2) begin
               hdr_profile = b[7:6];
               hdr_rate = b[5:2];
            end else if (frame_pos == 13'd3) begin
               hdr_length = {b[1:0], 11'd0};
            end else if (frame_pos == 13'd4) begin
               hdr_length = hdr_length | ({5'd0, b} << 3);
            end else if (frame_pos == 13'd5) begin
               hdr_length = hdr_length | {10'd0, b[7:5]};
            end
            nxt = frame_pos + 1;
            if (nxt == HDR_BYTES) begin
               done = (hdr_length <= HDR_BYTES);
               beats[0] = make_beat(b, 1'b1, 1'b0, done, 1'b1, 1'b1,
                                    hdr_length < HDR_BYTES);
            end else begin
               show = (nxt > HDR_BYTES);
               done = show && (nxt >= hdr_length);
               beats[0] = make_beat(b, 1'b1, 1'b0, done, 1'b0, show, 1'b0);
            end
            n = 1;
            if (done) begin
               frame_index = frame_index + 16'd1;
               skip_count = 16'd0;
               frame_pos = 13'd0;
               parse_phase = PH_HUNT;
            end else begin
               frame_pos = 13'(nxt);
            end
         end
      endcase
      if (n > 0) beats[n - 1].last_result = 1'b1;
      for (int i = 0; i < n; i++) pending_beats.push_back(beats[i]);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);
      deframe_byte(b);
      bytes_sent++;
   endtask

   // A frame of length below seven still runs to the end of its header.
   task automatic send_frame(input logic [12:0] len, input logic [1:0] prof,
                             input logic [3:0] rate, input logic [3:0] nib);
      logic [7:0]  hdr [7];
      logic [31:0] r;
      int          total;
      r = $urandom;
      hdr[0] = SYNC_BYTE;
      hdr[1] = {SYNC_NIBBLE, nib};
      hdr[2] = {prof, rate, r[1:0]};
      hdr[3] = {r[7:2], len[12:11]};
      hdr[4] = len[10:3];
      hdr[5] = {len[2:0], r[12:8]};
      hdr[6] = r[20:13];
      total = (len > HDR_BYTES) ? 32'(len) : 32'(HDR_BYTES);
      for (int i = 0; i < 7; i++) send_byte(hdr[i]);
      for (int i = 7; i < total; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic return_to_hunt();
      while (parse_phase != PH_HUNT) send_byte(8'h00);
   endtask

   task automatic test_directed();
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
      send_byte(8'h0E);
      send_byte(SYNC_BYTE);
      send_byte(8'hEF);
      send_frame(13'd7, 2'd3, 4'd15, 4'hF);
      send_frame(13'd0, 2'd0, 4'd0, 4'h0);
      send_frame(13'd8, 2'd2, 4'd5, 4'h9);
   endtask

   task automatic test_random_stream();
      int          stop_at;
      int          pick;
      int          sel;
      logic [12:0] len;
      return_to_hunt();
      stop_at = bytes_sent + 1000;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) len = 13'($urandom_range(0, 6));
            else if (sel == 1) len = 13'($urandom_range(100, 400));
            else len = 13'($urandom_range(7, 40));
            send_frame(len, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)));
         end else if (pick < 9) begin
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 2) == 0) send_byte(SYNC_BYTE);
               else send_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            send_byte(SYNC_BYTE);
            send_byte({4'($urandom_range(0, 14)), 4'($urandom_range(0, 15))});
         end
      end
      idle_on = 1'b1;
   endtask

   function automatic string beat_text(input result_type r);
      return $sformatf({"byte=%h cls=%0d first=%0d eof=%0d hdr=%0d prof=%0d rate=%0d",
                        " len=%0d skip=%0d cnt=%0d lerr=%0d last=%0d"},
                       r.out_byte, r.byte_class, r.first_of_frame, r.end_of_frame,
                       r.header_done, r.profile, r.rate_index, r.frame_length,
                       r.bytes_skipped, r.frame_count, r.length_error, r.last_result);
   endfunction

   initial begin
      result_type got;
      result_type want;
      int         gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = idle_on ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (rsp_valid !== 1'b1);
         got.out_byte       = rsp_out_byte;
         got.byte_class     = rsp_byte_class;
         got.first_of_frame = rsp_first_of_frame;
         got.end_of_frame   = rsp_end_of_frame;
         got.header_done    = rsp_header_done;
         got.profile        = rsp_profile;
         got.rate_index     = rsp_rate_index;
         got.frame_length   = rsp_frame_length;
         got.bytes_skipped  = rsp_bytes_skipped;
         got.frame_count    = rsp_frame_count;
         got.length_error   = rsp_length_error;
         got.last_result    = rsp_last_result;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected beat: %s", beat_text(got));
         end else begin
            want = pending_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_class !== want.byte_class ||
                got.first_of_frame !== want.first_of_frame ||
                got.end_of_frame !== want.end_of_frame ||
                got.header_done !== want.header_done || got.profile !== want.profile ||
                got.rate_index !== want.rate_index ||
                got.frame_length !== want.frame_length ||
                got.bytes_skipped !== want.bytes_skipped ||
                got.frame_count !== want.frame_count ||
                got.length_error !== want.length_error ||
                got.last_result !== want.last_result) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch at %0t", $realtime);
                  $display("  expected %s", beat_text(want));
                  $display("  actual   %s", beat_text(got));
               end
            end
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_adts_frame_deframer: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stream();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) $display("tb_adts_frame_deframer: clean");
      else $display("tb_adts_frame_deframer: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/adts_pkg.sv
src/adts_core.sv
src/adts_queue.sv
src/adts_frame_deframer.sv
sim/tb_adts_frame_deframer.sv
